// File: src/teq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants of the timed event queue
// Request codes, status codes, the command passed from front to back and the
// result record passed from back to the output stage.
// ----------------------------------------------------------------------------
package teq_pkg;

	// Field widths of the request and result ports
	localparam int FUNC_W   = 2;
	localparam int IO_TIME_W = 32;
	localparam int KIND_W   = 8;
	localparam int TAG_W    = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	// Defaults of the top-level parameters
	localparam int DEF_CAPACITY  = 16;
	localparam int DEF_TIME_BITS = 32;

	// Request codes on the func port
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_POP    = 2'd1;
	localparam logic [FUNC_W-1:0] FN_PURGE  = 2'd2;

	// Kind removed by a purge
	localparam logic [KIND_W-1:0] PURGE_KIND = 8'd1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Classified operation
	typedef enum logic [1:0] {
		OP_INSERT,
		OP_POP,
		OP_PURGE,
		OP_NONE
	} op_t;

	// Back-end sequencer states
	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} back_state_t;

	// Command from front to back
	typedef struct packed {
		op_t                  op;
		logic [IO_TIME_W-1:0] event_time;
		logic [KIND_W-1:0]    event_kind;
		logic [TAG_W-1:0]     event_tag;
	} cmd_t;

	// Result record
	typedef struct packed {
		logic                 out_valid;
		logic [IO_TIME_W-1:0] out_time;
		logic [KIND_W-1:0]    out_kind;
		logic [TAG_W-1:0]     out_tag;
		logic [STATUS_W-1:0]  status;
		logic [OCC_W-1:0]     occupancy;
	} result_t;

endpackage

// File: src/timed_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue: time-ordered event queue
// Usage:
//   Requests enter through push/full: func selects insert, pop earliest or
//   purge of all kind-1 events; event_time, event_kind and event_tag carry
//   the entry to insert. A request is taken when push is high and full low.
//   Every request gives exactly one result, offered while empty is low and
//   taken when pop is high; results leave in request order.
//   A request passes the command queue, the compare register and the result
//   register. The slot array ends one request before it takes the next: the
//   idle state registers the compares, the exec state shifts and waits for
//   the result register; a purge closes one gap per cycle until no kind-1 is left.
//   A two-entry command queue sits in front of the slot array and a result
//   register behind it; when the receiver stalls, the result register
//   holds, the slot array waits, then the command queue fills and full
//   rises. Nothing is lost.
//   Reset empties the queue, the command queue and the result register;
//   slot contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module timed_event_queue #(
	parameter int CAPACITY  = teq_pkg::DEF_CAPACITY,
	parameter int TIME_BITS = teq_pkg::DEF_TIME_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [teq_pkg::FUNC_W-1:0]    func,
	input  logic [teq_pkg::IO_TIME_W-1:0] event_time,
	input  logic [teq_pkg::KIND_W-1:0]    event_kind,
	input  logic [teq_pkg::TAG_W-1:0]     event_tag,
	output logic                          empty,
	input  logic                          pop,
	output logic                          out_valid,
	output logic [teq_pkg::IO_TIME_W-1:0] out_time,
	output logic [teq_pkg::KIND_W-1:0]    out_kind,
	output logic [teq_pkg::TAG_W-1:0]     out_tag,
	output logic [teq_pkg::STATUS_W-1:0]  status,
	output logic [teq_pkg::OCC_W-1:0]     occupancy
);
	import teq_pkg::*;

	logic    cmd_valid;
	cmd_t    cmd;
	logic    cmd_take;
	logic    res_valid;
	result_t res;
	logic    res_ready;

	// Intake and classification
	teq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.event_time (event_time),
		.event_kind (event_kind),
		.event_tag  (event_tag),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take)
	);

	// Sorted slot array
	teq_back #(
		.CAPACITY  (CAPACITY),
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// Result register
	teq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_time  (out_time),
		.out_kind  (out_kind),
		.out_tag   (out_tag),
		.status    (status),
		.occupancy (occupancy)
	);

endmodule

// File: src/teq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_front: request intake
// Accepts requests, classifies the function code and holds them in a
// two-entry command queue in front of the back end.
// ----------------------------------------------------------------------------
module teq_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [teq_pkg::FUNC_W-1:0] func,
	input  logic [teq_pkg::IO_TIME_W-1:0] event_time,
	input  logic [teq_pkg::KIND_W-1:0] event_kind,
	input  logic [teq_pkg::TAG_W-1:0]  event_tag,
	output logic                       cmd_valid,
	output teq_pkg::cmd_t              cmd,
	input  logic                       cmd_take
);
	import teq_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	cmd_t       in_cmd;
	logic       do_wr;
	logic       do_rd;

	// Classify the function code
	always_comb begin
		in_cmd.event_time = event_time;
		in_cmd.event_kind = event_kind;
		in_cmd.event_tag  = event_tag;
		unique case (func)
			FN_INSERT: in_cmd.op = OP_INSERT;
			FN_POP:    in_cmd.op = OP_POP;
			FN_PURGE:  in_cmd.op = OP_PURGE;
			default:   in_cmd.op = OP_NONE;
		endcase
	end

	assign full      = (fill_q == 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign do_wr     = push && !full;
	assign do_rd     = cmd_take && cmd_valid;

	// Store the accepted request
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// File: src/teq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_back: sorted slot array and its sequencer
// A row of slots kept in time order, head in slot 0. Each slot compares its
// time with the incoming one; the masks are registered, then the slots shift
// in one step. A purge removes the first kind-1 entry per cycle.
// ----------------------------------------------------------------------------
module teq_back #(
	parameter int CAPACITY  = teq_pkg::DEF_CAPACITY,
	parameter int TIME_BITS = teq_pkg::DEF_TIME_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  teq_pkg::cmd_t    cmd,
	output logic             cmd_take,
	output logic             res_valid,
	output teq_pkg::result_t res,
	input  logic             res_ready
);
	import teq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Slot storage
	logic [TIME_BITS-1:0] slot_time_q [CAPACITY];
	logic [KIND_W-1:0]    slot_kind_q [CAPACITY];
	logic [TAG_W-1:0]     slot_tag_q  [CAPACITY];
	logic [CNT_W-1:0]     count_q;

	// Neighbour views
	logic [TIME_BITS-1:0] prev_time [CAPACITY];
	logic [KIND_W-1:0]    prev_kind [CAPACITY];
	logic [TAG_W-1:0]     prev_tag  [CAPACITY];
	logic [TIME_BITS-1:0] next_time [CAPACITY];
	logic [KIND_W-1:0]    next_kind [CAPACITY];
	logic [TAG_W-1:0]     next_tag  [CAPACITY];

	// Compare stage
	back_state_t          state_q;
	back_state_t          state_d;
	op_t                  op_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic [KIND_W-1:0]    kind_s1;
	logic [TAG_W-1:0]     tag_s1;
	logic [CAPACITY-1:0]  ge_s1;
	logic [CAPACITY-1:0]  valid_s1;
	logic                 le_all_s1;

	logic [63:0]          cmd_time64;
	logic [TIME_BITS-1:0] new_time;
	logic [63:0]          head_time64;
	logic [CAPACITY-1:0]  valid_vec;
	logic [CAPACITY-1:0]  ge_vec;
	logic [CAPACITY-1:0]  le_vec;
	logic [CAPACITY-1:0]  hit_vec;
	logic [CAPACITY-1:0]  purge_mask;
	logic [CAPACITY-1:0]  ins_mask;
	logic [CAPACITY-1:0]  ins_prev;
	logic                 is_full;
	logic                 is_empty;
	logic                 do_insert;
	logic                 do_pop;
	logic                 purge_step;
	logic                 load_s1;

	assign cmd_time64  = 64'(cmd.event_time);
	assign new_time    = cmd_time64[TIME_BITS-1:0];
	assign head_time64 = 64'(slot_time_q[0]);
	assign is_full     = (count_q == CNT_W'(CAPACITY));
	assign is_empty    = (count_q == '0);

	// Per-slot compares and neighbour wiring
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
		assign valid_vec[i] = (CNT_W'(i) < count_q);
		assign ge_vec[i]    = !valid_vec[i] || (slot_time_q[i] >= new_time);
		assign le_vec[i]    = !valid_vec[i] || (slot_time_q[i] <= new_time);
		assign hit_vec[i]   = valid_vec[i] && (slot_kind_q[i] == PURGE_KIND);
		if (i == 0) begin : g_first
			assign purge_mask[i] = hit_vec[i];
			assign prev_time[i]  = slot_time_q[i];
			assign prev_kind[i]  = slot_kind_q[i];
			assign prev_tag[i]   = slot_tag_q[i];
		end else begin : g_rest
			assign purge_mask[i] = purge_mask[i-1] | hit_vec[i];
			assign prev_time[i]  = slot_time_q[i-1];
			assign prev_kind[i]  = slot_kind_q[i-1];
			assign prev_tag[i]   = slot_tag_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_time[i] = slot_time_q[i];
			assign next_kind[i] = slot_kind_q[i];
			assign next_tag[i]  = slot_tag_q[i];
		end else begin : g_inner
			assign next_time[i] = slot_time_q[i+1];
			assign next_kind[i] = slot_kind_q[i+1];
			assign next_tag[i]  = slot_tag_q[i+1];
		end
	end

	// Insert position: front on head tie, back when at or above tail
	assign ins_mask = (ge_s1[0] || !le_all_s1) ? ge_s1 : ~valid_s1;
	assign ins_prev = {ins_mask[CAPACITY-2:0], 1'b0};

	// Sequencer: next state and outputs
	always_comb begin
		state_d    = state_q;
		cmd_take   = 1'b0;
		load_s1    = 1'b0;
		res_valid  = 1'b0;
		do_insert  = 1'b0;
		do_pop     = 1'b0;
		purge_step = 1'b0;
		res        = '0;
		res.status    = ST_OK;
		res.occupancy = OCC_W'(count_q);
		unique case (state_q)
			BK_IDLE: begin
				cmd_take = cmd_valid;
				load_s1  = cmd_valid;
				if (cmd_valid) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				unique case (op_s1)
					OP_INSERT: begin
						res_valid = 1'b1;
						if (is_full) begin
							res.status = ST_FULL;
						end else begin
							res.occupancy = OCC_W'(count_q + CNT_W'(1));
						end
						do_insert = res_ready && !is_full;
					end
					OP_POP: begin
						res_valid = 1'b1;
						if (is_empty) begin
							res.status = ST_EMPTY;
						end else begin
							res.out_valid = 1'b1;
							res.out_time  = head_time64[IO_TIME_W-1:0];
							res.out_kind  = slot_kind_q[0];
							res.out_tag   = slot_tag_q[0];
							res.occupancy = OCC_W'(count_q - CNT_W'(1));
						end
						do_pop = res_ready && !is_empty;
					end
					OP_PURGE: begin
						purge_step = |hit_vec;
						res_valid  = !(|hit_vec);
					end
					default: begin
						res_valid = 1'b1;
					end
				endcase
				if (res_valid && res_ready) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Register the command and its compare masks
	always_ff @(posedge clk) begin
		if (load_s1) begin
			op_s1     <= cmd.op;
			time_s1   <= new_time;
			kind_s1   <= cmd.event_kind;
			tag_s1    <= cmd.event_tag;
			ge_s1     <= ge_vec;
			valid_s1  <= valid_vec;
			le_all_s1 <= &le_vec;
		end
	end

	// Shift the slots: open a gap on insert, close one on pop or purge
	for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
		always_ff @(posedge clk) begin
			if (do_insert && ins_mask[i]) begin
				if (!ins_prev[i]) begin
					slot_time_q[i] <= time_s1;
					slot_kind_q[i] <= kind_s1;
					slot_tag_q[i]  <= tag_s1;
				end else begin
					slot_time_q[i] <= prev_time[i];
					slot_kind_q[i] <= prev_kind[i];
					slot_tag_q[i]  <= prev_tag[i];
				end
			end else if (do_pop || (purge_step && purge_mask[i])) begin
				slot_time_q[i] <= next_time[i];
				slot_kind_q[i] <= next_kind[i];
				slot_tag_q[i]  <= next_tag[i];
			end
		end
	end

	// Track the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (do_pop || purge_step) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// File: src/teq_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_out: result register
// Holds one finished result until it is popped, so the back end can move on
// to the next request while the receiver stalls.
// ----------------------------------------------------------------------------
module teq_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          res_valid,
	input  teq_pkg::result_t              res,
	output logic                          res_ready,
	output logic                          empty,
	input  logic                          pop,
	output logic                          out_valid,
	output logic [teq_pkg::IO_TIME_W-1:0] out_time,
	output logic [teq_pkg::KIND_W-1:0]    out_kind,
	output logic [teq_pkg::TAG_W-1:0]     out_tag,
	output logic [teq_pkg::STATUS_W-1:0]  status,
	output logic [teq_pkg::OCC_W-1:0]     occupancy
);
	import teq_pkg::*;

	logic    held_q;
	result_t data_q;

	assign empty     = !held_q;
	assign res_ready = !held_q || pop;

	// Hold the waiting result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (res_ready) begin
			held_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

	assign out_valid = data_q.out_valid;
	assign out_time  = data_q.out_time;
	assign out_kind  = data_q.out_kind;
	assign out_tag   = data_q.out_tag;
	assign status    = data_q.status;
	assign occupancy = data_q.occupancy;

endmodule

// File: verif/timed_event_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue_tb: self-checking regression of the timed event queue
// A directed pass covers the corner cases: pop and purge on an empty queue,
// the unused code, equal times at head and tail, a middle insert, a fill to
// capacity with a dropped insert, and purges of head, middle and tail
// entries. Random traffic follows in four phases of sender and receiver
// idling, filling and draining in turns. Each result is checked in order
// against a predicted schedule.
// ----------------------------------------------------------------------------
module timed_event_queue_tb;
	import teq_pkg::*;

	localparam int CAPACITY = DEF_CAPACITY;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam int RANDOM_PER_PHASE = 370;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [IO_TIME_W-1:0] t;
		logic [KIND_W-1:0]    k;
		logic [TAG_W-1:0]     g;
	} sched_entry_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [FUNC_W-1:0]    func = FN_INSERT;
	logic [IO_TIME_W-1:0] event_time = '0;
	logic [KIND_W-1:0]    event_kind = '0;
	logic [TAG_W-1:0]     event_tag = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic                 out_valid;
	logic [IO_TIME_W-1:0] out_time;
	logic [KIND_W-1:0]    out_kind;
	logic [TAG_W-1:0]     out_tag;
	logic [STATUS_W-1:0]  status;
	logic [OCC_W-1:0]     occupancy;

	// Predicted schedule and results still owed by the block
	sched_entry_t schedule[$];
	result_t      owed_results[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int results_checked = 0;
	int requests_sent = 0;
	int events_popped = 0;
	int empty_pops = 0;
	int dropped_inserts = 0;
	int purged_entries = 0;
	int peak_occupancy = 0;

	timed_event_queue dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.event_time (event_time),
		.event_kind (event_kind),
		.event_tag  (event_tag),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_time   (out_time),
		.out_kind   (out_kind),
		.out_tag    (out_tag),
		.status     (status),
		.occupancy  (occupancy)
	);

	always #2 clk = ~clk;

	// Apply one request to the predicted schedule and return its result
	function automatic result_t schedule_request(logic [FUNC_W-1:0] f,
			logic [IO_TIME_W-1:0] t, logic [KIND_W-1:0] k, logic [TAG_W-1:0] g);
		result_t      r;
		sched_entry_t e;
		sched_entry_t kept[$];
		int           pos;
		r = '0;
		r.status = ST_OK;
		case (f)
			FN_INSERT: begin
				if (schedule.size() >= CAPACITY) begin
					r.status = ST_FULL;
					dropped_inserts++;
				end else begin
					e.t = t;
					e.k = k;
					e.g = g;
					if (schedule.size() == 0 || t <= schedule[0].t) begin
						pos = 0;
					end else if (t >= schedule[schedule.size()-1].t) begin
						pos = schedule.size();
					end else begin
						pos = 1;
						while (pos < schedule.size() && schedule[pos].t < t)
							pos++;
					end
					schedule.insert(pos, e);
				end
			end
			FN_POP: begin
				if (schedule.size() == 0) begin
					r.status = ST_EMPTY;
					empty_pops++;
				end else begin
					e = schedule.pop_front();
					r.out_valid = 1'b1;
					r.out_time = e.t;
					r.out_kind = e.k;
					r.out_tag = e.g;
					events_popped++;
				end
			end
			FN_PURGE: begin
				foreach (schedule[i])
					if (schedule[i].k != PURGE_KIND)
						kept.push_back(schedule[i]);
				purged_entries += schedule.size() - kept.size();
				schedule = kept;
			end
			default: ;
		endcase
		r.occupancy = OCC_W'(schedule.size());
		if (schedule.size() > peak_occupancy)
			peak_occupancy = schedule.size();
		return r;
	endfunction

	// Present one request, hold it until taken, then record its result
	task automatic send_request(logic [FUNC_W-1:0] f, logic [IO_TIME_W-1:0] t,
			logic [KIND_W-1:0] k, logic [TAG_W-1:0] g);
		bit taken;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		func <= f;
		event_time <= t;
		event_kind <= k;
		event_tag <= g;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !full;
		end
		owed_results.push_back(schedule_request(f, t, k, g));
		requests_sent++;
	endtask

	// Check each result taken; drive pop with random stalls
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				got.out_valid = out_valid;
				got.out_time = out_time;
				got.out_kind = out_kind;
				got.out_tag = out_tag;
				got.status = status;
				got.occupancy = occupancy;
				if (owed_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: result with no request outstanding", $realtime);
				end else begin
					want = owed_results.pop_front();
					results_checked++;
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display({"%0t: result %0d mismatch: expected v=%0b t=%h k=%h g=%h ",
								"st=%0d occ=%0d, got v=%0b t=%h k=%h g=%h st=%0d occ=%0d"},
								$realtime, results_checked,
								want.out_valid, want.out_time, want.out_kind, want.out_tag,
								want.status, want.occupancy,
								got.out_valid, got.out_time, got.out_kind, got.out_tag,
								got.status, got.occupancy);
					end
				end
			end
			pop <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Corner cases with no idling
	task automatic test_directed();
		send_request(FN_POP, 32'h0, 8'h0, 16'h0);
		send_request(FN_PURGE, 32'h0, 8'h0, 16'h0);
		send_request(FN_UNUSED, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
		// empty take, front, back, equal-time middle, equal head, equal tail
		send_request(FN_INSERT, 32'd100, PURGE_KIND, 16'h0000);
		send_request(FN_INSERT, 32'h0, 8'hFF, 16'hFFFF);
		send_request(FN_INSERT, 32'hFFFF_FFFF, 8'h00, 16'h0001);
		send_request(FN_INSERT, 32'd100, 8'h07, 16'h0002);
		send_request(FN_INSERT, 32'h0, PURGE_KIND, 16'h0003);
		send_request(FN_INSERT, 32'hFFFF_FFFF, PURGE_KIND, 16'h0004);
		// drop head, middle and tail kind-1 entries
		send_request(FN_PURGE, 32'h0, 8'h0, 16'h0);
		// fill to capacity, then overflow
		for (int i = 0; i < CAPACITY - 3; i++)
			send_request(FN_INSERT, 32'(i * 37 + 1), (i % 2) ? PURGE_KIND : 8'(i + 2),
				16'(16'hA000 + i));
		send_request(FN_INSERT, 32'd5, 8'h09, 16'hBEEF);
		send_request(FN_PURGE, 32'h0, 8'h0, 16'h0);
		send_request(FN_POP, 32'h0, 8'h0, 16'h0);
		send_request(FN_POP, 32'h0, 8'h0, 16'h0);
	endtask

	// Random traffic that fills and drains the queue in turns
	task automatic run_random(int count);
		bit                   filling;
		int                   tide_left;
		int                   roll;
		logic [FUNC_W-1:0]    f;
		logic [IO_TIME_W-1:0] t;
		logic [KIND_W-1:0]    k;
		filling = 1'($urandom_range(0, 1));
		tide_left = $urandom_range(10, 50);
		for (int n = 0; n < count; n++) begin
			if (tide_left == 0) begin
				filling = !filling;
				tide_left = $urandom_range(10, 50);
			end
			tide_left--;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				f = FN_UNUSED;
			else if (roll < 10)
				f = FN_PURGE;
			else if (roll < (filling ? 80 : 35))
				f = FN_INSERT;
			else
				f = FN_POP;
			// favour small times so that equal times are common
			roll = $urandom_range(0, 99);
			if (roll < 40)
				t = $urandom_range(0, 15);
			else if (roll < 50)
				t = roll[0] ? 32'hFFFF_FFFF : 32'h0;
			else
				t = $urandom;
			roll = $urandom_range(0, 99);
			if (roll < 30)
				k = PURGE_KIND;
			else if (roll < 40)
				k = roll[0] ? 8'hFF : 8'h00;
			else
				k = 8'($urandom_range(0, 255));
			send_request(f, t, k, 16'($urandom));
		end
	endtask

	task automatic test_no_idle();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random(RANDOM_PER_PHASE);
	endtask

	task automatic test_sender_idle();
		send_idle_pct = 70;
		recv_stall_pct = 0;
		run_random(RANDOM_PER_PHASE);
	endtask

	task automatic test_receiver_stall();
		send_idle_pct = 0;
		recv_stall_pct = 70;
		run_random(RANDOM_PER_PHASE);
	endtask

	task automatic test_both_idle();
		send_idle_pct = 20;
		recv_stall_pct = 20;
		run_random(RANDOM_PER_PHASE);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		push <= 1'b0;
		// drain owed results, then watch for strays
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d requests, %0d results checked, %0d mismatches.",
			requests_sent, results_checked, mismatch_count);
		$display("Popped %0d events, %0d empty pops, %0d full drops, %0d purged, peak %0d.",
			events_popped, empty_pops, dropped_inserts, purged_entries, peak_occupancy);
		if (mismatch_count == 0)
			$display("timed_event_queue regression: pass");
		else
			$display("timed_event_queue regression: fail");
		$finish;
	end

	// Stop a hung run
	initial begin
		#2ms;
		$display("Timed out with %0d results outstanding.", owed_results.size());
		$display("timed_event_queue regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
src/teq_pkg.sv
src/teq_front.sv
src/teq_back.sv
src/teq_out.sv
src/timed_event_queue.sv
verif/timed_event_queue_tb.sv
